FILE: rtl/core/gb3_pkg.sv
package gb3_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int DimW      = 11;
  localparam int WeightW   = 16;
  localparam int AddrW     = 3;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [AddrW-1:0] RegLineWidth   = 3'd0;
  localparam logic [AddrW-1:0] RegFrameHeight = 3'd1;
  localparam logic [AddrW-1:0] RegWeightCtr   = 3'd2;
  localparam logic [AddrW-1:0] RegWeightEdge  = 3'd3;
  localparam logic [AddrW-1:0] RegWeightCorn  = 3'd4;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       first_of_frame;
    logic       flush;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_of_frame;
  } out_beat_t;

  // One classified item handed from front to back.
  typedef struct packed {
    logic [7:0]  pix;
    logic        first;
    logic        flush;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } work_t;

  typedef struct packed {
    logic [WeightW-1:0] center;
    logic [WeightW-1:0] edge_w;
    logic [WeightW-1:0] corner;
  } weights_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                               input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    begin
      r = v;
      if (v < DimW'(3)) r = DimW'(3);
      else if (v > maxv) r = maxv;
      return r;
    end
  endfunction

endpackage

FILE: rtl/core/gaussian_blur_3x3.sv
// Channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | in_beat_t (pixel_in, first_of_frame, flush)
// out     | out | out_valid/out_stall | out_beat_t (pixel_out, last_of_frame)
// cfg     | in  | APB psel/penable    | five registers at 4*i
// One pixel per clock sustained while no stall holds the flow; the beat completing
// a window passes the queue, line store read and multiply before the output register.
// Results trail input by line_width+1 items; flush items drain the tail.
// Synchronous active-high reset; line stores are not cleared.
// A stalled result freezes the back pipeline; the queue absorbs four beats.
module gaussian_blur_3x3 import gb3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [DimW-1:0] line_width, frame_height;
  weights_t        wts;
  logic            wr;
  logic [AddrW-1:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  // Hold configuration registers; write at the APB access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= DimW'(640);
      frame_height <= DimW'(480);
      wts.center <= 16'd631;
      wts.edge_w <= 16'd488;
      wts.corner <= 16'd378;
    end else if (wr) begin
      unique case (idx)
        RegLineWidth:   line_width <= pwdata[DimW-1:0];
        RegFrameHeight: frame_height <= pwdata[DimW-1:0];
        RegWeightCtr:   wts.center <= pwdata[15:0];
        RegWeightEdge:  wts.edge_w <= pwdata[15:0];
        RegWeightCorn:  wts.corner <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegLineWidth:   prdata = 32'(line_width);
      RegFrameHeight: prdata = 32'(frame_height);
      RegWeightCtr:   prdata = 32'(wts.center);
      RegWeightEdge:  prdata = 32'(wts.edge_w);
      RegWeightCorn:  prdata = 32'(wts.corner);
      default:        prdata = '0;
    endcase
  end

  // Queue between front and back: small circular buffer.
  work_t q_mem [QueueDepth];
  logic [QueuePtrW:0] wp, rp;
  logic q_full, q_valid, q_push, q_pop;
  work_t q_in;

  assign q_full = (wp - rp) == (QueuePtrW+1)'(QueueDepth);
  assign q_valid = wp != rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0;
    end else begin
      if (q_push) wp <= wp + 1'b1;
      if (q_pop) rp <= rp + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (q_push) q_mem[wp[QueuePtrW-1:0]] <= q_in;
  end

  gb3_front u_front (
    .in_valid, .in_data, .line_width, .frame_height,
    .q_full, .in_stall, .q_push, .q_data(q_in));

  gb3_back u_back (
    .clk, .rst, .q_valid, .q_data(q_mem[rp[QueuePtrW-1:0]]), .q_pop, .wts,
    .out_valid, .out_data, .out_stall);
endmodule

FILE: rtl/core/gb3_ram.sv
module gb3_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/gb3_front.sv
module gb3_front import gb3_pkg::*; (
  input  logic            in_valid,
  input  in_beat_t        in_data,
  input  logic [DimW-1:0] line_width,
  input  logic [DimW-1:0] frame_height,
  input  logic            q_full,
  output logic            in_stall,
  output logic            q_push,
  output work_t           q_data
);
  // Tag each beat; idle flushes are dropped in the back, which owns the frame position.
  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  always_comb begin
    q_data.pix   = in_data.flush ? 8'd0 : in_data.pixel_in;
    q_data.first = in_data.first_of_frame;
    q_data.flush = in_data.flush;
    q_data.w     = clamp_dim(line_width, DimW'(MaxWidth));
    q_data.h     = clamp_dim(frame_height, DimW'(MaxHeight));
  end
endmodule

FILE: rtl/core/gb3_back.sv
module gb3_back import gb3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  work_t     q_data,
  output logic      q_pop,
  input  weights_t  wts,
  output logic      out_valid,
  output out_beat_t out_data,
  input  logic      out_stall
);
  // Stage 1: line store read + window shift. Stage 2: multiplies.
  // Stage 3: sum/round/saturate (centre pass-through on borders) into output register.
  logic [ColW-1:0] col;
  logic [DimW:0]   pend;
  logic [DimW-1:0] row, ocol;
  logic            adv;
  logic [ColW-1:0] c_col;
  logic [DimW:0]   c_pend;
  logic [DimW-1:0] c_row, c_ocol;

  // Stage-1 registered item
  logic            s1_v, s1_emit, s1_border, s1_last;
  logic [7:0]      s1_pix;
  logic [ColW-1:0] s1_col;
  logic [7:0]      top_rd, mid_rd;
  logic [7:0]      win [3][3];
  logic [7:0]      t_pix, m_pix;
  logic            s1_byp;
  logic [7:0]      s1_mid_w;
  logic [7:0]      s1_pix_w;

  // Stage-2
  logic            s2_v, s2_border, s2_last;
  logic [7:0]      s2_ctr;
  logic [23:0]     p_c;
  logic [25:0]     p_e, p_k;

  logic            hold;
  logic            drop;

  assign hold = out_valid && out_stall;
  assign adv = !hold;
  assign q_pop = q_valid && adv;

  // Same-column read-after-write bypass: stage 1 writes column s1_col.
  logic byp;
  assign byp = s1_v && s1_col == c_col;

  always_comb begin
    c_col = q_data.first ? '0 : col;
    c_pend = q_data.first ? '0 : pend;
    c_row = q_data.first ? '0 : row;
    c_ocol = q_data.first ? '0 : ocol;
  end

  // A flush with no open frame is dropped and enters no stage.
  assign drop = q_data.flush && c_pend == '0;

  assign t_pix = s1_byp ? s1_mid_w : top_rd;
  assign m_pix = s1_byp ? s1_pix_w : mid_rd;

  gb3_ram #(.Width(8), .Depth(MaxWidth)) u_top (
    .clk, .we(s1_v && adv), .waddr(s1_col), .wdata(m_pix),
    .re(q_pop), .raddr(c_col), .rdata(top_rd));
  gb3_ram #(.Width(8), .Depth(MaxWidth)) u_mid (
    .clk, .we(s1_v && adv), .waddr(s1_col), .wdata(s1_pix),
    .re(q_pop), .raddr(c_col), .rdata(mid_rd));

  logic [DimW:0] n_ocol;
  logic          emit, border, last;
  always_comb begin
    emit = c_pend >= {1'b0, q_data.w} + 1'b1;
    border = c_row == '0 || c_row >= q_data.h - 1'b1 || c_ocol == '0 ||
             c_ocol >= q_data.w - 1'b1;
    last = c_row >= q_data.h - 1'b1 && c_ocol >= q_data.w - 1'b1;
    n_ocol = {1'b0, c_ocol} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; pend <= '0; row <= '0; ocol <= '0;
      s1_v <= 1'b0; s2_v <= 1'b0; out_valid <= 1'b0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] <= '0;
    end else begin
      if (adv) begin
        s1_v <= q_pop && !drop;
        if (s1_v) begin
          for (int r = 0; r < 3; r++) begin
            win[r][0] <= win[r][1];
            win[r][1] <= win[r][2];
          end
          win[0][2] <= t_pix;
          win[1][2] <= m_pix;
          win[2][2] <= s1_pix;
        end
        if (q_pop) begin
          if (drop) begin
            // A frame mark on a dropped flush still clears the position.
            col <= c_col; pend <= c_pend; row <= c_row; ocol <= c_ocol;
          end else begin
            s1_byp <= byp;
            s1_mid_w <= m_pix;
            s1_pix_w <= s1_pix;
            s1_pix <= q_data.pix;
            s1_col <= c_col;
            s1_emit <= emit;
            s1_border <= border;
            s1_last <= last;
            if ({1'b0, c_col} + 1'b1 >= {1'b0, q_data.w}) col <= '0;
            else col <= c_col + 1'b1;
            if (!emit) begin
              pend <= c_pend + 1'b1;
              row <= c_row; ocol <= c_ocol;
            end else if (last) begin
              pend <= '0; row <= '0; ocol <= '0; col <= '0;
            end else begin
              pend <= c_pend;
              if (n_ocol >= {1'b0, q_data.w}) begin
                ocol <= '0; row <= c_row + 1'b1;
              end else begin
                ocol <= n_ocol[DimW-1:0]; row <= c_row;
              end
            end
          end
        end
        s2_v <= s1_v && s1_emit;
        out_valid <= s2_v;
      end
    end
  end

  // Window after stage-1 update is what stage 2 multiplies; use next values.
  logic [7:0] nw [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nw[r][0] = win[r][1];
      nw[r][1] = win[r][2];
    end
    nw[0][2] = t_pix; nw[1][2] = m_pix; nw[2][2] = s1_pix;
  end

  logic [9:0] esum, ksum;
  assign esum = 10'(nw[0][1]) + 10'(nw[2][1]) + 10'(nw[1][0]) + 10'(nw[1][2]);
  assign ksum = 10'(nw[0][0]) + 10'(nw[0][2]) + 10'(nw[2][0]) + 10'(nw[2][2]);

  logic [27:0] total;
  assign total = 28'(p_c) + 28'(p_e) + 28'(p_k) + 28'd2048;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctr <= nw[1][1];
      s2_border <= s1_border;
      s2_last <= s1_last;
      p_c <= wts.center * nw[1][1];
      p_e <= wts.edge_w * esum;
      p_k <= wts.corner * ksum;
      out_data.last_of_frame <= s2_last;
      if (s2_border) out_data.pixel_out <= s2_ctr;
      else if (total[27:12] > 16'd255) out_data.pixel_out <= 8'hFF;
      else out_data.pixel_out <= total[19:12];
    end
  end
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import gb3_pkg::*;

  localparam int LimitCycles = 1000000;
  localparam int SettleCycles = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gaussian_blur_3x3 u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: line stores, window, positions and registers.
  bit [7:0] row_mem [0:2*MaxWidth-1];
  bit [7:0] win [3][3];
  int unsigned in_col, out_row, out_col, fill_count;
  int unsigned cfg_width, cfg_height, wt_center, wt_edge, wt_corner;

  out_beat_t expected_pixels[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;     // no gaps and no new stalls while set
  int stall_left = 0;
  int stall_roll;
  bit frame_open = 1'b0; // a frame is in progress in the block
  int random_items = 0;

  function automatic int unsigned clamp_size(int unsigned v);
    if (v < 3) return 3;
    if (v > MaxWidth) return MaxWidth;
    return v;
  endfunction

  // Advance the blur predictor by one accepted beat; queue a result if one is due.
  function automatic void blur_predict(input in_beat_t b);
    int unsigned w, h, col, v, c;
    bit [7:0] pix, top, mid;
    bit last;
    longint unsigned s, e, k;
    out_beat_t r;
    w = clamp_size(cfg_width);
    h = clamp_size(cfg_height);
    pix = b.flush ? 8'd0 : b.pixel_in;
    if (b.first_of_frame) begin
      in_col = 0; out_row = 0; out_col = 0; fill_count = 0;
    end
    if (b.flush && fill_count == 0) return;
    col = (in_col >= MaxWidth) ? 0 : in_col;
    top = row_mem[col];
    mid = row_mem[MaxWidth + col];
    row_mem[col] = mid;
    row_mem[MaxWidth + col] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    in_col = col + 1;
    if (in_col >= w) in_col = 0;
    if (fill_count < w + 1) begin
      fill_count++;
      return;
    end
    if (out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1) begin
      v = win[1][1];
    end else begin
      s = longint'(wt_center) * win[1][1];
      e = win[0][1] + win[2][1] + win[1][0] + win[1][2];
      k = win[0][0] + win[0][2] + win[2][0] + win[2][2];
      s = s + longint'(wt_edge) * e + longint'(wt_corner) * k;
      s = (s + 2048) >> 12;
      v = (s > 255) ? 255 : int'(s);
    end
    last = (out_row >= h - 1) && (out_col >= w - 1);
    c = out_col + 1;
    if (c >= w) begin
      c = 0;
      out_row++;
    end
    out_col = c;
    if (last) begin
      in_col = 0; out_row = 0; out_col = 0; fill_count = 0;
    end
    r.pixel_out = v[7:0];
    r.last_of_frame = last;
    expected_pixels.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one input beat, hold it until accepted, then idle for a random gap.
  task automatic send_beat(input in_beat_t b);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    blur_predict(b);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, wait for all expected results, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [AddrW-1:0] idx, input int unsigned val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegLineWidth:   cfg_width = val & 32'h7ff;
      RegFrameHeight: cfg_height = val & 32'h7ff;
      RegWeightCtr:   wt_center = val & 32'hffff;
      RegWeightEdge:  wt_edge = val & 32'hffff;
      RegWeightCorn:  wt_corner = val & 32'hffff;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    cfg_write(RegLineWidth, w);
    cfg_write(RegFrameHeight, h);
  endtask

  task automatic set_weights(input int unsigned c, input int unsigned e,
                             input int unsigned k);
    cfg_write(RegWeightCtr, c);
    cfg_write(RegWeightEdge, e);
    cfg_write(RegWeightCorn, k);
  endtask

  // Send a frame. pix_mode: 0 random, 1 all 0xff, 2 all zero.
  // cut > 0 stops after that many pixels and leaves the frame open.
  task automatic send_frame(input int pix_mode, input bit mark_first,
                            input int flush_pct, input int cut);
    int unsigned w, h, n;
    in_beat_t b;
    w = clamp_size(cfg_width);
    h = clamp_size(cfg_height);
    n = (cut > 0) ? cut : w * h;
    for (int i = 0; i < n; i++) begin
      b.pixel_in = (pix_mode == 1) ? 8'hff : (pix_mode == 2) ? 8'h00 : 8'($urandom);
      b.first_of_frame = (i == 0) && (mark_first || frame_open);
      b.flush = ($urandom_range(0, 99) < flush_pct);
      send_beat(b);
    end
    if (cut > 0) begin
      frame_open = 1'b1;
      return;
    end
    for (int i = 0; i <= w; i++) begin
      b.pixel_in = 8'($urandom);
      b.first_of_frame = 1'b0;
      b.flush = 1'b1;
      send_beat(b);
    end
    frame_open = 1'b0;
  endtask

  task automatic stray_flushes(input int count);
    in_beat_t b;
    for (int i = 0; i < count; i++) begin
      b.pixel_in = 8'($urandom);
      b.first_of_frame = 1'b0;
      b.flush = 1'b1;
      send_beat(b);
    end
  endtask

  task automatic test_smallest_frame();
    set_frame(3, 3);
    set_weights(631, 488, 378);
    stray_flushes(3);
    send_frame(1, 1'b1, 0, 0);
    send_frame(2, 1'b1, 0, 0);
    send_frame(0, 1'b0, 0, 0);
    wait_idle();
  endtask

  task automatic test_weight_extremes();
    set_frame(4, 4);
    set_weights(65535, 65535, 65535);
    send_frame(1, 1'b1, 0, 0);
    send_frame(0, 1'b1, 0, 0);
    wait_idle();
    set_weights(0, 0, 0);
    send_frame(0, 1'b1, 0, 0);
    wait_idle();
    set_weights(4096, 0, 0);
    send_frame(0, 1'b1, 0, 0);
    wait_idle();
  endtask

  task automatic test_size_clamp();
    set_weights(631, 488, 378);
    set_frame(0, 0);
    send_frame(0, 1'b1, 0, 0);
    wait_idle();
    set_frame(5, 2);
    send_frame(0, 1'b1, 0, 0);
    wait_idle();
    set_frame(3, 2047);
    send_frame(0, 1'b1, 0, 30);
    wait_idle();
  endtask

  task automatic test_flush_and_restart();
    set_frame(5, 4);
    send_frame(0, 1'b1, 30, 0);
    stray_flushes(2);
    send_frame(0, 1'b1, 0, 7);
    send_frame(0, 1'b1, 0, 0);
    wait_idle();
  endtask

  // Mostly well-formed small frames with random content, some cut short,
  // some with flushes inside, and stray flushes while idle.
  task automatic test_random_frames();
    int unsigned w, h, r, cut_len;
    while (random_items < 200) begin
      if (!frame_open && $urandom_range(0, 3) == 0) begin
        wait_idle();
        r = $urandom_range(0, 9);
        w = (r == 0) ? $urandom_range(9, 24) : $urandom_range(3, 8);
        h = (r == 1) ? $urandom_range(7, 12) : $urandom_range(3, 6);
        set_frame(w, h);
        r = $urandom_range(0, 3);
        if (r == 0) set_weights($urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535));
        else if (r == 1) set_weights($urandom_range(0, 1000), $urandom_range(0, 800),
                                     $urandom_range(0, 600));
        else set_weights(631, 488, 378);
      end
      quiet = ($urandom_range(0, 4) == 0);
      w = clamp_size(cfg_width);
      h = clamp_size(cfg_height);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        cut_len = $urandom_range(1, w * h - 1);
        send_frame(0, 1'b1, 0, cut_len);
        random_items += cut_len;
      end else begin
        send_frame(0, $urandom_range(0, 1), (r == 1) ? 20 : 0, 0);
        random_items += w * h + w + 1;
      end
      if ($urandom_range(0, 5) == 0 && !frame_open) stray_flushes($urandom_range(1, 3));
    end
    quiet = 1'b0;
  endtask

  // Receiver stall pattern: bursts of mostly short and a few long stalls.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_roll = $urandom_range(0, 99);
      if (!quiet && stall_roll < 20)
        stall_left = (stall_roll < 18) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got pixel %0d last %0b",
                 $time, out_data.pixel_out, out_data.last_of_frame);
        errors++;
      end else begin
        if (out_data.pixel_out !== expected_pixels[0].pixel_out) begin
          $display("%0t: pixel_out mismatch, expected %0d, got %0d", $time,
                   expected_pixels[0].pixel_out, out_data.pixel_out);
          errors++;
        end
        if (out_data.last_of_frame !== expected_pixels[0].last_of_frame) begin
          $display("%0t: last_of_frame mismatch, expected %0b, got %0b", $time,
                   expected_pixels[0].last_of_frame, out_data.last_of_frame);
          errors++;
        end
        void'(expected_pixels.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cfg_width = 640; cfg_height = 480;
    wt_center = 631; wt_edge = 488; wt_corner = 378;
    in_col = 0; out_row = 0; out_col = 0; fill_count = 0;
    foreach (row_mem[i]) row_mem[i] = 8'd0;
    foreach (win[i, j]) win[i][j] = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_smallest_frame();
    test_weight_extremes();
    test_size_clamp();
    test_flush_and_restart();
    test_random_frames();
    wait_idle();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/gb3_pkg.sv
rtl/core/gb3_ram.sv
rtl/core/gb3_front.sv
rtl/core/gb3_back.sv
rtl/core/gaussian_blur_3x3.sv
bench/testbench.sv
